// ===== rtl/hsvhr_pkg.sv =====
// Shared constants, register indexes and a helper function for the hue rotator.
`timescale 1ns / 1ps
package hsvhr_pkg;

   // Port widths
   localparam int IO_W         = 8;
   localparam int OFFSET_W     = 12;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 12;
   localparam int CHANNEL_BITS_DEF = 8;

   // Hue format: 256 units per sector, 1536 per circle
   localparam int QUOT_W       = 9;    // sector quotient 0..256
   localparam int HUE_W        = 11;   // wrapped hue 0..1535
   localparam int SUM_W        = 15;   // signed hue sum before wrap
   localparam int HUE_BIAS     = 4608; // three full circles keeps the sum positive

   // Hue base codes by max channel
   localparam logic [1:0] BASE_RED   = 2'd0;
   localparam logic [1:0] BASE_GREEN = 2'd1;
   localparam logic [1:0] BASE_BLUE  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 2'd1;

   // Sector numbers of the wrapped hue
   localparam logic [2:0] SEC_0 = 3'd0;
   localparam logic [2:0] SEC_1 = 3'd1;
   localparam logic [2:0] SEC_2 = 3'd2;
   localparam logic [2:0] SEC_3 = 3'd3;
   localparam logic [2:0] SEC_4 = 3'd4;

   // Remainder of a 4-bit count of thirds of a circle by three
   function automatic logic [1:0] mod3_4b(input logic [3:0] v);
      logic [1:0] m;
      case (v)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       m = 2'd1;
         default:                              m = 2'd2;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/hsvhr_front.sv =====
// Front stage: max, min, chroma and hue numerator selection for one pixel.
`timescale 1ns / 1ps
module hsvhr_front #(
   parameter int CHANNEL_BITS = hsvhr_pkg::CHANNEL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [hsvhr_pkg::IO_W-1:0]    red,
   input  logic [hsvhr_pkg::IO_W-1:0]    green,
   input  logic [hsvhr_pkg::IO_W-1:0]    blue,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [CHANNEL_BITS+9:0]       num,
   output logic [CHANNEL_BITS:0]         den,
   output logic [5*CHANNEL_BITS+3:0]     side
);
   import hsvhr_pkg::*;

   localparam int W = CHANNEL_BITS;

   logic [W-1:0] r, g, b, mx, mn, d, na, nb, mag;
   logic [1:0]   base;
   logic         neg, pass;

   logic              vld_ff;
   logic [W+9:0]      num_ff, num_in;
   logic [W:0]        den_ff, den_in;
   logic [5*W+3:0]    side_ff, side_in;

   // Mask inputs to the channel width
   assign r = W'(red);
   assign g = W'(green);
   assign b = W'(blue);

   // Find extremes and the first max channel
   always_comb begin
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      d = mx - mn;
      if (mx == r) begin
         na = g; nb = b; base = BASE_RED;
      end else if (mx == g) begin
         na = b; nb = r; base = BASE_GREEN;
      end else begin
         na = r; nb = g; base = BASE_BLUE;
      end
      neg  = na < nb;
      mag  = neg ? (nb - na) : (na - nb);
      pass = !enable || (d == '0);
      num_in  = ((W+10)'(mag) << 9) + (W+10)'(d);
      den_in  = {d, 1'b0};
      side_in = {r, g, b, mn, d, neg, base, pass};
   end

   assign in_ready = !vld_ff || out_ready;

   // Advance when this stage is empty or the next stage can take the item
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
      if (in_ready) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff;
   assign num       = num_ff;
   assign den       = den_ff;
   assign side      = side_ff;

endmodule

// ===== rtl/hsvhr_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
`timescale 1ns / 1ps
module hsvhr_div #(
   parameter int NUM_W  = 18,
   parameter int DEN_W  = 9,
   parameter int SIDE_W = 44
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [NUM_W-1:0]              num,
   input  logic [DEN_W-1:0]              den,
   input  logic [SIDE_W-1:0]             side_in,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [hsvhr_pkg::QUOT_W-1:0]  quot,
   output logic [SIDE_W-1:0]             side_out
);
   import hsvhr_pkg::*;

   localparam int N = QUOT_W;

   logic              vld_src [0:N];
   logic [NUM_W-1:0]  rem_src [0:N];
   logic [DEN_W-1:0]  den_src [0:N];
   logic [N-1:0]      quo_src [0:N];
   logic [SIDE_W-1:0] sid_src [0:N];
   logic              rdy     [0:N];

   assign vld_src[0] = in_valid;
   assign rem_src[0] = num;
   assign den_src[0] = den;
   assign quo_src[0] = '0;
   assign sid_src[0] = side_in;
   assign rdy[N]     = out_ready;
   assign in_ready   = rdy[0];

   for (genvar s = 0; s < N; s++) begin : g_stage
      localparam int B = N - 1 - s;
      logic              vld_ff;
      logic [NUM_W-1:0]  rem_ff, rem_in;
      logic [DEN_W-1:0]  den_ff;
      logic [N-1:0]      quo_ff, quo_in;
      logic [SIDE_W-1:0] sid_ff;
      logic [NUM_W-1:0]  trial;

      // Subtract the shifted divisor where it fits
      always_comb begin
         trial  = NUM_W'(den_src[s]) << B;
         rem_in = rem_src[s];
         quo_in = quo_src[s];
         if (rem_src[s] >= trial) begin
            rem_in    = rem_src[s] - trial;
            quo_in[B] = 1'b1;
         end
      end

      assign rdy[s] = !vld_ff || rdy[s+1];

      // Hold while the next stage is full and stalled
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff <= vld_src[s];
         end
         if (rdy[s]) begin
            rem_ff <= rem_in;
            den_ff <= den_src[s];
            quo_ff <= quo_in;
            sid_ff <= sid_src[s];
         end
      end

      assign vld_src[s+1] = vld_ff;
      assign rem_src[s+1] = rem_ff;
      assign den_src[s+1] = den_ff;
      assign quo_src[s+1] = quo_ff;
      assign sid_src[s+1] = sid_ff;
   end

   assign out_valid = vld_src[N];
   assign quot      = quo_src[N];
   assign side_out  = sid_src[N];

endmodule

// ===== rtl/hsvhr_back.sv =====
// Back stages: hue wrap, sector interpolation and RGB rebuild.
`timescale 1ns / 1ps
module hsvhr_back #(
   parameter int CHANNEL_BITS = hsvhr_pkg::CHANNEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [hsvhr_pkg::OFFSET_W-1:0] hue_offset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [hsvhr_pkg::QUOT_W-1:0]        quot,
   input  logic [5*CHANNEL_BITS+3:0]           side,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [hsvhr_pkg::IO_W-1:0]          red,
   output logic [hsvhr_pkg::IO_W-1:0]          green,
   output logic [hsvhr_pkg::IO_W-1:0]          blue
);
   import hsvhr_pkg::*;

   localparam int W = CHANNEL_BITS;

   // Unpack sideband
   logic [W-1:0] s_r, s_g, s_b, s_mn, s_d;
   logic         s_neg, s_pass;
   logic [1:0]   s_base;
   assign {s_r, s_g, s_b, s_mn, s_d, s_neg, s_base, s_pass} = side;

   // Stage A: wrap the rotated hue, find sector and ramp
   logic signed [SUM_W-1:0] hsum;
   logic [12:0]             hpos;
   logic [HUE_W-1:0]        hue;
   logic [8:0]              f;
   logic [QUOT_W-1:0]       t_in;

   always_comb begin
      hsum = $signed({4'b0, s_base, 9'b0})
           + (s_neg ? -$signed({6'b0, quot}) : $signed({6'b0, quot}))
           + SUM_W'(hue_offset) + SUM_W'(HUE_BIAS);
      hpos = hsum[12:0];
      hue  = {mod3_4b(hpos[12:9]), hpos[8:0]};
      f    = hue[8:0];
      t_in = f[8] ? QUOT_W'(10'd512 - {1'b0, f}) : f;
   end

   logic              a_vld_ff, a_rdy;
   logic [2:0]        a_sec_ff;
   logic [QUOT_W-1:0] a_t_ff;
   logic [QUOT_W-1:0] a_q_ff;
   logic [3*W-1:0]    a_rgb_ff;
   logic [W-1:0]      a_mn_ff, a_d_ff;
   logic              a_pass_ff;

   logic              b_vld_ff, b_rdy;
   logic [2:0]        b_sec_ff;
   logic [W-1:0]      b_x_ff, b_x_in;
   logic [3*W-1:0]    b_rgb_ff;
   logic [W-1:0]      b_mn_ff, b_d_ff;
   logic              b_pass_ff;
   logic [QUOT_W-1:0] b_t_ff;

   logic              c_vld_ff, c_rdy;
   logic [IO_W-1:0]   c_r_ff, c_g_ff, c_b_ff;
   logic [W-1:0]      ro, go, bo;

   assign c_rdy    = !c_vld_ff || out_ready;
   assign b_rdy    = !b_vld_ff || c_rdy;
   assign a_rdy    = !a_vld_ff || b_rdy;
   assign in_ready = a_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_rdy) begin
         a_vld_ff <= in_valid;
      end
      if (a_rdy) begin
         a_sec_ff  <= hue[10:8];
         a_t_ff    <= t_in;
         a_q_ff    <= quot;
         a_rgb_ff  <= {s_r, s_g, s_b};
         a_mn_ff   <= s_mn;
         a_d_ff    <= s_d;
         a_pass_ff <= s_pass;
      end
   end

   // Stage B: second component from chroma and ramp
   logic [W+8:0] prod;
   always_comb begin
      prod   = (W+9)'(a_d_ff) * (W+9)'(a_t_ff) + (W+9)'(128);
      b_x_in = prod[W+7:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (b_rdy) begin
         b_vld_ff <= a_vld_ff;
      end
      if (b_rdy) begin
         b_sec_ff  <= a_sec_ff;
         b_x_ff    <= b_x_in;
         b_rgb_ff  <= a_rgb_ff;
         b_mn_ff   <= a_mn_ff;
         b_d_ff    <= a_d_ff;
         b_pass_ff <= a_pass_ff;
         b_t_ff    <= a_t_ff;
      end
   end

   // Stage C: place chroma and second component by sector and add min, or pass the input through
   always_comb begin
      ro = '0;
      go = '0;
      bo = '0;
      case (b_sec_ff)
         SEC_0:   begin ro = b_d_ff; go = b_x_ff; end
         SEC_1:   begin ro = b_x_ff; go = b_d_ff; end
         SEC_2:   begin go = b_d_ff; bo = b_x_ff; end
         SEC_3:   begin go = b_x_ff; bo = b_d_ff; end
         SEC_4:   begin ro = b_x_ff; bo = b_d_ff; end
         default: begin ro = b_d_ff; bo = b_x_ff; end
      endcase
      if (b_pass_ff) begin
         {ro, go, bo} = b_rgb_ff;
      end else begin
         ro = ro + b_mn_ff;
         go = go + b_mn_ff;
         bo = bo + b_mn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (c_rdy) begin
         c_vld_ff <= b_vld_ff;
      end
      if (c_rdy) begin
         c_r_ff <= IO_W'(ro);
         c_g_ff <= IO_W'(go);
         c_b_ff <= IO_W'(bo);
      end
   end

   assign out_valid = c_vld_ff;
   assign red       = c_r_ff;
   assign green     = c_g_ff;
   assign blue      = c_b_ff;

   // Quotient of a colored pixel never passes one full sector
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && !a_pass_ff |-> a_q_ff <= QUOT_W'(256))
      else $error("hue quotient out of range");

   // Ramp stays within one sector
   a_ramp_range: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> b_t_ff <= QUOT_W'(256))
      else $error("sector ramp out of range");

   // A stalled output stage must hold the stage before it
   a_hold_b: assert property (@(posedge clock) disable iff (reset)
      c_vld_ff && !out_ready && b_vld_ff |=> b_vld_ff)
      else $error("item dropped under stall");

endmodule

// ===== rtl/hsv_hue_rotate_pixel.sv =====
// Top level: HSV hue rotation of one RGB pixel per item, with config registers.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | red_in, green_in, blue_in
//   rsp     | out       | rsp_valid/stall    | red_out, green_out, blue_out
//   csr     | in        | csr_write          | csr_index, csr_wdata
//
// One item per cycle while rsp is not stalled; the stages are one front stage, nine
// divider stages (one quotient bit each), and three back stages.
// Reset is synchronous; it empties the pipeline and sets offset 0, enable 1.
// A stall on rsp holds full stages; empty stages keep filling, so req_stall
// rises only once every stage holds an item.
`timescale 1ns / 1ps
module hsv_hue_rotate_pixel #(
   parameter int CHANNEL_BITS = hsvhr_pkg::CHANNEL_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hsvhr_pkg::IO_W-1:0]        req_red_in,
   input  logic [hsvhr_pkg::IO_W-1:0]        req_green_in,
   input  logic [hsvhr_pkg::IO_W-1:0]        req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hsvhr_pkg::IO_W-1:0]        rsp_red_out,
   output logic [hsvhr_pkg::IO_W-1:0]        rsp_green_out,
   output logic [hsvhr_pkg::IO_W-1:0]        rsp_blue_out,
   input  logic                              csr_write,
   input  logic [hsvhr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hsvhr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hsvhr_pkg::*;

   localparam int W = CHANNEL_BITS;

   logic signed [OFFSET_W-1:0] hue_offset_ff;
   logic                       enable_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_offset_ff <= '0;
         enable_ff     <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HUE_OFFSET: hue_offset_ff <= $signed(csr_wdata[OFFSET_W-1:0]);
            CSR_ENABLE:     enable_ff     <= csr_wdata[0];
            default:        ;
         endcase
      end
   end

   logic             f_valid, f_ready, d_valid, d_ready, front_ready;
   logic [W+9:0]     f_num;
   logic [W:0]       f_den;
   logic [5*W+3:0]   f_side, d_side;
   logic [QUOT_W-1:0] d_quot;

   hsvhr_front #(.CHANNEL_BITS(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .num       (f_num),
      .den       (f_den),
      .side      (f_side)
   );

   hsvhr_div #(.NUM_W(W+10), .DEN_W(W+1), .SIDE_W(5*W+4)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .num       (f_num),
      .den       (f_den),
      .side_in   (f_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .quot      (d_quot),
      .side_out  (d_side)
   );

   hsvhr_back #(.CHANNEL_BITS(W)) u_back (
      .clock      (clock),
      .reset      (reset),
      .hue_offset (hue_offset_ff),
      .in_valid   (d_valid),
      .in_ready   (d_ready),
      .quot       (d_quot),
      .side       (d_side),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .red        (rsp_red_out),
      .green      (rsp_green_out),
      .blue       (rsp_blue_out)
   );

   assign req_stall = !front_ready;

   // An empty output stage never backs up the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

// ===== bench/hsv_hue_rotate_checker.sv =====
// Checker for the hue rotator: predicts each pixel and compares results in order.
`timescale 1ns / 1ps
module hsv_hue_rotate_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_red_out,
   input  logic [7:0]  rsp_green_out,
   input  logic [7:0]  rsp_blue_out,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import hsvhr_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   pixel_type  rotated_q[$];
   logic signed [11:0] offset_ff;
   logic       enable_ff;

   // Rotate the hue of one pixel
   function automatic pixel_type rotate_pixel(input pixel_type p);
      int r, g, b, mx, mn, c, n, base, mag, q, h, sec, f, t, x, ro, go, bo;
      pixel_type o;
      r = p.red; g = p.green; b = p.blue;
      mx = r > g ? r : g; if (b > mx) mx = b;
      mn = r < g ? r : g; if (b < mn) mn = b;
      c = mx - mn;
      if (!enable_ff || c == 0) return p;
      if (mx == r) begin
         n = g - b; base = 0;
      end else if (mx == g) begin
         n = b - r; base = 512;
      end else begin
         n = r - g; base = 1024;
      end
      mag = n < 0 ? -n : n;
      q = (512 * mag + c) / (2 * c);
      h = ((n < 0 ? base - q : base + q) + 1536) % 1536;
      h = (h + int'(offset_ff) + 3072) % 1536;
      sec = h / 256;
      f = h % 512;
      t = f >= 256 ? 512 - f : f;
      x = (c * t + 128) >> 8;
      ro = 0; go = 0; bo = 0;
      case (sec)
         0: begin ro = c; go = x; end
         1: begin ro = x; go = c; end
         2: begin go = c; bo = x; end
         3: begin go = x; bo = c; end
         4: begin ro = x; bo = c; end
         default: begin ro = c; bo = x; end
      endcase
      o.red = 8'(ro + mn); o.green = 8'(go + mn); o.blue = 8'(bo + mn);
      return o;
   endfunction

   assign pending = rotated_q.size();

   // Track registers, predict accepted items, compare accepted results
   always @(posedge clock) begin
      pixel_type want;
      int errs;
      errs = 0;
      if (reset) begin
         offset_ff <= '0;
         enable_ff <= 1'b1;
         rotated_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_write && csr_index == CSR_HUE_OFFSET) offset_ff <= csr_wdata;
         if (csr_write && csr_index == CSR_ENABLE) enable_ff <= csr_wdata[0];
         if (req_valid && !req_stall)
            rotated_q.push_back(rotate_pixel({req_red_in, req_green_in, req_blue_in}));
         if (rsp_valid && !rsp_stall) begin
            if (rotated_q.size() == 0) begin
               $error("result with no item pending");
               errs = errs + 1;
            end else begin
               want = rotated_q.pop_front();
               if (want.red !== rsp_red_out) begin
                  $error("red_out expected %0d actual %0d", want.red, rsp_red_out);
                  errs = errs + 1;
               end
               if (want.green !== rsp_green_out) begin
                  $error("green_out expected %0d actual %0d", want.green, rsp_green_out);
                  errs = errs + 1;
               end
               if (want.blue !== rsp_blue_out) begin
                  $error("blue_out expected %0d actual %0d", want.blue, rsp_blue_out);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

// ===== bench/tb_hsv_hue_rotate_pixel.sv =====
// Testbench top: drives pixels and register writes into the hue rotator.
`timescale 1ns / 1ps
module tb_hsv_hue_rotate_pixel;
   import hsvhr_pkg::*;

   // Index of no register
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic [7:0] req_red_in, req_green_in, req_blue_in;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic csr_write;
   logic [1:0] csr_index;
   logic [11:0] csr_wdata;
   int fail_count, pending, cycles;
   bit quiet;

   hsv_hue_rotate_pixel dut (.*);
   hsv_hue_rotate_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Abort on a runaway run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side stalls in random bursts
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               rsp_stall <= 1;
               @(posedge clock);
            end
            rsp_stall <= 0;
         end
      end
   end

   // Offer one item, sometimes after a random gap, and hold it until accepted
   task automatic send_pixel(input int r, g, b);
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 6);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_red_in <= 8'(r); req_green_in <= 8'(g); req_blue_in <= 8'(b);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drain the pipeline, then write one register
   task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic random_pixel();
      logic [7:0] r, g, b;
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(0, 7))
         0: g = r;
         1: b = g;
         2: begin g = r; b = r; end
         3: begin r = 8'hff; b = 0; end
         default: ;
      endcase
      send_pixel(int'(r), int'(g), int'(b));
   endtask

   initial begin
      logic [11:0] offsets[8];
      cycles = 0; quiet = 0;
      reset = 1; req_valid = 0; req_red_in = 0; req_green_in = 0; req_blue_in = 0;
      csr_write = 0; csr_index = 0; csr_wdata = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: primaries, secondaries, greys, ties, extremes at reset offset, then offset and enable settings
      send_pixel(255, 0, 0);   send_pixel(0, 255, 0);   send_pixel(0, 0, 255);
      send_pixel(255, 255, 0); send_pixel(0, 255, 255); send_pixel(255, 0, 255);
      send_pixel(0, 0, 0);     send_pixel(255, 255, 255); send_pixel(128, 128, 128);
      send_pixel(255, 254, 0); send_pixel(1, 0, 0);     send_pixel(3, 2, 1);
      write_reg(CSR_HUE_OFFSET, 12'd1536);
      send_pixel(255, 0, 0); send_pixel(10, 200, 90);
      write_reg(CSR_HUE_OFFSET, -12'sd1536);
      send_pixel(255, 0, 0); send_pixel(200, 10, 90);
      write_reg(CSR_HUE_OFFSET, 12'h7ff);
      send_pixel(40, 90, 250); send_pixel(255, 0, 1);
      write_reg(CSR_HUE_OFFSET, 12'h800);
      send_pixel(40, 90, 250); send_pixel(0, 1, 255);
      write_reg(CSR_ENABLE, 12'hffe);
      send_pixel(255, 0, 0); send_pixel(12, 34, 56);
      write_reg(CSR_UNUSED, 12'hfff);
      write_reg(CSR_ENABLE, 12'h001);
      send_pixel(12, 34, 56);

      // Random phases across settings
      offsets = '{12'd0, 12'd256, 12'd1536, -12'sd1536, 12'h7ff, 12'h800, 12'd768, 12'd1};
      for (int ph = 0; ph < 10; ph++) begin
         if (ph < 8) write_reg(CSR_HUE_OFFSET, offsets[ph]);
         else write_reg(CSR_HUE_OFFSET, 12'($urandom));
         write_reg(CSR_ENABLE, ph == 3 ? 12'd0 : 12'hfff);
         if (ph == 9) quiet = 1;
         for (int i = 0; i < 112; i++) begin
            random_pixel();
            // Hold off once until the pipeline drains
            if (ph == 5 && i == 50) begin
               req_valid <= 0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
